// ===== rtl/core/btnc_pkg.sv =====
// Package for the B+ tree internal node child search unit.
// Holds sizes, operation and status codes, FSM states and shared structs.
// No dependencies.
`timescale 1ns / 1ps

package btnc_pkg;

	localparam int CAPACITY = 256;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 32;
	localparam int POS_W    = 8;

	typedef enum logic [2:0] {
		MODE_WR_KEY   = 3'd0,
		MODE_WR_CHILD = 3'd1,
		MODE_RD_ENTRY = 3'd2,
		MODE_LOOKUP   = 3'd3,
		MODE_FIND     = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_RANGE     = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN_KEY,
		S_SCAN_CHILD,
		S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		RES_NONE,
		RES_ENTRY,
		RES_CHILD
	} kind_t;

	typedef struct packed {
		logic              key_we;
		logic              child_we;
		logic [ADDR_W-1:0] wr_addr;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} ram_ctl_t;

	typedef struct packed {
		logic                    load;
		logic signed [KEY_W-1:0] key;
		logic signed [KEY_W-1:0] child;
		logic [POS_W-1:0]        position;
		status_t                 status;
	} res_t;

endpackage

// ===== rtl/core/btnc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds while read enable is low. No dependencies.
`timescale 1ns / 1ps

module btnc_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/core/btnc_engine.sv =====
// Sequencer for the node table: writes, entry reads, key lookup scan and child scan.
// Drives both table RAMs and hands one result word to the output stage. Uses btnc_pkg.
`timescale 1ns / 1ps

module btnc_engine (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [2:0]                         mode,
	input  logic [7:0]                         slot,
	input  logic signed [btnc_pkg::KEY_W-1:0]  search_key,
	input  logic signed [btnc_pkg::KEY_W-1:0]  child_ref,
	input  logic [btnc_pkg::CNT_W-1:0]         used,
	input  logic signed [btnc_pkg::KEY_W-1:0]  key_rd_data,
	input  logic signed [btnc_pkg::KEY_W-1:0]  child_rd_data,
	input  logic                               out_free,
	output btnc_pkg::ram_ctl_t                 ram_ctl,
	output btnc_pkg::res_t                     res
);

	btnc_pkg::state_t                  state_q, state_d;
	btnc_pkg::kind_t                   kind_q, kind_d;
	btnc_pkg::status_t                 status_q, status_d;
	logic [btnc_pkg::ADDR_W-1:0]       cur_q, cur_d;
	logic [btnc_pkg::ADDR_W-1:0]       pos_q, pos_d;
	logic signed [btnc_pkg::KEY_W-1:0] key_q, key_d;
	logic signed [btnc_pkg::KEY_W-1:0] child_q, child_d;
	logic [btnc_pkg::ADDR_W-1:0]       last;
	logic                              slot_ok;
	logic                              accept;

	assign last    = btnc_pkg::ADDR_W'(used - btnc_pkg::CNT_W'(1));
	assign slot_ok = btnc_pkg::CNT_W'(slot) < used;
	assign accept  = in_valid && (state_q == btnc_pkg::S_IDLE);
	assign in_stall = (state_q != btnc_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= btnc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q   <= kind_d;
		status_q <= status_d;
		cur_q    <= cur_d;
		pos_q    <= pos_d;
		key_q    <= key_d;
		child_q  <= child_d;
	end

	always_comb begin
		state_d  = state_q;
		kind_d   = kind_q;
		status_d = status_q;
		cur_d    = cur_q;
		pos_d    = pos_q;
		key_d    = key_q;
		child_d  = child_q;
		ram_ctl.key_we   = 1'b0;
		ram_ctl.child_we = 1'b0;
		ram_ctl.wr_addr  = btnc_pkg::ADDR_W'(slot);
		ram_ctl.rd_en    = 1'b0;
		ram_ctl.rd_addr  = cur_q;
		res.load     = 1'b0;
		res.key      = '0;
		res.child    = '0;
		res.position = btnc_pkg::POS_W'(pos_q);
		res.status   = status_q;
		if (kind_q == btnc_pkg::RES_ENTRY) begin
			res.key = key_rd_data;
		end
		if (kind_q != btnc_pkg::RES_NONE) begin
			res.child = child_rd_data;
		end

		unique case (state_q)
			btnc_pkg::S_IDLE: begin
				if (accept) begin
					key_d    = search_key;
					child_d  = child_ref;
					kind_d   = btnc_pkg::RES_NONE;
					status_d = btnc_pkg::ST_OK;
					pos_d    = '0;
					state_d  = btnc_pkg::S_EMIT;
					case (mode)
						btnc_pkg::MODE_WR_KEY: begin
							ram_ctl.key_we = slot_ok;
							if (!slot_ok) begin
								status_d = btnc_pkg::ST_RANGE;
							end
						end
						btnc_pkg::MODE_WR_CHILD: begin
							ram_ctl.child_we = slot_ok;
							if (!slot_ok) begin
								status_d = btnc_pkg::ST_RANGE;
							end
						end
						btnc_pkg::MODE_RD_ENTRY: begin
							if (slot_ok) begin
								ram_ctl.rd_en   = 1'b1;
								ram_ctl.rd_addr = btnc_pkg::ADDR_W'(slot);
								kind_d          = btnc_pkg::RES_ENTRY;
							end else begin
								status_d = btnc_pkg::ST_RANGE;
							end
						end
						btnc_pkg::MODE_LOOKUP: begin
							if (used == '0) begin
								status_d = btnc_pkg::ST_EMPTY;
							end else if (used == btnc_pkg::CNT_W'(1)) begin
								ram_ctl.rd_en   = 1'b1;
								ram_ctl.rd_addr = '0;
								kind_d          = btnc_pkg::RES_CHILD;
							end else begin
								ram_ctl.rd_en   = 1'b1;
								ram_ctl.rd_addr = btnc_pkg::ADDR_W'(1);
								cur_d           = btnc_pkg::ADDR_W'(1);
								state_d         = btnc_pkg::S_SCAN_KEY;
							end
						end
						btnc_pkg::MODE_FIND: begin
							if (used == '0) begin
								status_d = btnc_pkg::ST_NOT_FOUND;
							end else begin
								ram_ctl.rd_en   = 1'b1;
								ram_ctl.rd_addr = '0;
								cur_d           = '0;
								state_d         = btnc_pkg::S_SCAN_CHILD;
							end
						end
						default: begin
							status_d = btnc_pkg::ST_NOT_FOUND;
						end
					endcase
				end
			end
			btnc_pkg::S_SCAN_KEY: begin
				if (key_rd_data > key_q) begin
					pos_d           = cur_q - btnc_pkg::ADDR_W'(1);
					ram_ctl.rd_en   = 1'b1;
					ram_ctl.rd_addr = cur_q - btnc_pkg::ADDR_W'(1);
					kind_d          = btnc_pkg::RES_CHILD;
					state_d         = btnc_pkg::S_EMIT;
				end else if (cur_q == last) begin
					pos_d   = cur_q;
					kind_d  = btnc_pkg::RES_CHILD;
					state_d = btnc_pkg::S_EMIT;
				end else begin
					ram_ctl.rd_en   = 1'b1;
					ram_ctl.rd_addr = cur_q + btnc_pkg::ADDR_W'(1);
					cur_d           = cur_q + btnc_pkg::ADDR_W'(1);
				end
			end
			btnc_pkg::S_SCAN_CHILD: begin
				if (child_rd_data == child_q) begin
					pos_d   = cur_q;
					state_d = btnc_pkg::S_EMIT;
				end else if (cur_q == last) begin
					status_d = btnc_pkg::ST_NOT_FOUND;
					state_d  = btnc_pkg::S_EMIT;
				end else begin
					ram_ctl.rd_en   = 1'b1;
					ram_ctl.rd_addr = cur_q + btnc_pkg::ADDR_W'(1);
					cur_d           = cur_q + btnc_pkg::ADDR_W'(1);
				end
			end
			btnc_pkg::S_EMIT: begin
				if (out_free) begin
					res.load = 1'b1;
					state_d  = btnc_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = btnc_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/btree_node_child_search_unit.sv =====
// Top level of the B+ tree internal node child search unit.
// Writes, entry reads, range errors, empty-table cases and unused modes need no scan; key lookup
// scans at most n - 1 keys and child find at most n children, n = entries in use.
// One word in work at a time: the next word is taken in the cycle after the result loads, and
// a stalled result holds the engine. The scan reads one entry per cycle.
// Reset clears the count register and the handshake state; table RAMs are not cleared.
`timescale 1ns / 1ps

module btree_node_child_search_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [btnc_pkg::CNT_W-1:0]         cfg_wr_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [2:0]                         mode,
	input  logic [7:0]                         slot,
	input  logic signed [btnc_pkg::KEY_W-1:0]  search_key,
	input  logic signed [btnc_pkg::KEY_W-1:0]  child_ref,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [btnc_pkg::KEY_W-1:0]  key_out,
	output logic signed [btnc_pkg::KEY_W-1:0]  child_out,
	output logic [7:0]                         position,
	output logic [1:0]                         status
);

	logic [btnc_pkg::CNT_W-1:0]        entries_in_use_q;
	logic [btnc_pkg::CNT_W-1:0]        used;
	logic signed [btnc_pkg::KEY_W-1:0] key_rd_data;
	logic signed [btnc_pkg::KEY_W-1:0] child_rd_data;
	logic                              out_free;
	btnc_pkg::ram_ctl_t                ram_ctl;
	btnc_pkg::res_t                    res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_in_use_q <= '0;
		end else if (cfg_wr_en) begin
			entries_in_use_q <= cfg_wr_data;
		end
	end

	assign used = (entries_in_use_q > btnc_pkg::CNT_W'(btnc_pkg::CAPACITY)) ?
		btnc_pkg::CNT_W'(btnc_pkg::CAPACITY) : entries_in_use_q;

	assign out_free = !out_valid || !out_stall;

	btnc_engine u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.slot          (slot),
		.search_key    (search_key),
		.child_ref     (child_ref),
		.used          (used),
		.key_rd_data   (key_rd_data),
		.child_rd_data (child_rd_data),
		.out_free      (out_free),
		.ram_ctl       (ram_ctl),
		.res           (res)
	);

	btnc_ram #(
		.DEPTH (btnc_pkg::CAPACITY),
		.WIDTH (btnc_pkg::KEY_W)
	) u_key_ram (
		.clk     (clk),
		.we      (ram_ctl.key_we),
		.wr_addr (ram_ctl.wr_addr),
		.wr_data (search_key),
		.rd_en   (ram_ctl.rd_en),
		.rd_addr (ram_ctl.rd_addr),
		.rd_data (key_rd_data)
	);

	btnc_ram #(
		.DEPTH (btnc_pkg::CAPACITY),
		.WIDTH (btnc_pkg::KEY_W)
	) u_child_ram (
		.clk     (clk),
		.we      (ram_ctl.child_we),
		.wr_addr (ram_ctl.wr_addr),
		.wr_data (child_ref),
		.rd_en   (ram_ctl.rd_en),
		.rd_addr (ram_ctl.rd_addr),
		.rd_data (child_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (res.load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.load) begin
			key_out   <= res.key;
			child_out <= res.child;
			position  <= res.position;
			status    <= res.status;
		end
	end

endmodule
